// ===== design/ksyn_pkg.sv =====
`timescale 1ns / 1ps
// shared types, scan codes and constant tables of the keyboard sine synth
package ksyn_pkg;

    localparam int KEY_W     = 8;
    localparam int VOICE_W   = 3;
    localparam int VOL_W     = 4;
    localparam int TICK_W    = 16;
    localparam int STEP_W    = 15;
    localparam int CFG_IDX_W = 4;
    localparam int NUM_CFG   = 8;
    localparam int OUT_W     = 32;
    localparam int PROD_W    = STEP_W + TICK_W;

    localparam logic [7:0] BREAK_CODE    = 8'hF0;
    localparam logic [7:0] VOL_UP_CODE   = 8'h55;
    localparam logic [7:0] VOL_DOWN_CODE = 8'h4E;

    localparam logic [7:0] NOTE_CODES [KEY_W] = '{
        8'h1C, 8'h1B, 8'h23, 8'h2B, 8'h3B, 8'h42, 8'h4B, 8'h4C
    };

    localparam logic [STEP_W-1:0] STEP_RESET [NUM_CFG] = '{
        15'd130, 15'd146, 15'd164, 15'd174, 15'd195, 15'd220, 15'd246, 15'd261
    };

    // q30 fixed point
    localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
    localparam logic [30:0] Q30_HALF_PI = 31'd1686629713;

    typedef struct packed {
        logic               take;
        logic               issue;
        logic [VOICE_W-1:0] voice;
        logic               load;
    } t_dp_cmd;

    typedef struct packed {
        logic emit;
        logic busy;
    } t_dp_sts;

    // divisor (2k+2)(2k+3) of series term k+1
    function automatic logic [8:0] f_series_div(input logic [2:0] k);
        logic [8:0] d;
        case (k)
            3'd0: d = 9'd6;
            3'd1: d = 9'd20;
            3'd2: d = 9'd42;
            3'd3: d = 9'd72;
            3'd4: d = 9'd110;
            3'd5: d = 9'd156;
            3'd6: d = 9'd210;
            3'd7: d = 9'd272;
            default: d = 9'd6;
        endcase
        return d;
    endfunction

    // floor(2^32 / divisor), quotient may come out one low
    function automatic logic [29:0] f_series_rcp(input logic [2:0] k);
        logic [29:0] m;
        case (k)
            3'd0: m = 30'd715827882;
            3'd1: m = 30'd214748364;
            3'd2: m = 30'd102261126;
            3'd3: m = 30'd59652323;
            3'd4: m = 30'd39045157;
            3'd5: m = 30'd27531841;
            3'd6: m = 30'd20452225;
            3'd7: m = 30'd15790320;
            default: m = 30'd715827882;
        endcase
        return m;
    endfunction

endpackage

// ===== design/ksyn_ram.sv =====
`timescale 1ns / 1ps
// generic single write port ram with registered read
module ksyn_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 48000
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/ksyn_sine_gen.sv =====
`timescale 1ns / 1ps
// sequencer that computes one sine period and writes it into the wave ram
module ksyn_sine_gen #(
    parameter int TABLE_LEN   = 48000,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    output logic                         o_wr_en,
    output logic [$clog2(TABLE_LEN)-1:0] o_wr_addr,
    output logic [SAMPLE_BITS-1:0]       o_wr_data,
    output logic                         o_done
);

    import ksyn_pkg::*;

    localparam int IDX_W = $clog2(TABLE_LEN);
    localparam int AMP_W = SAMPLE_BITS - 1;
    localparam int MP_W  = 31 + AMP_W;
    localparam logic [31:0]      INC_Q = 32'((64'd1 << 32) / TABLE_LEN);
    localparam logic [IDX_W-1:0] INC_R = IDX_W'((64'd1 << 32) % TABLE_LEN);
    localparam logic [IDX_W:0]   LEN_C = (IDX_W + 1)'(TABLE_LEN);
    localparam logic [AMP_W-1:0] AMP   = {AMP_W{1'b1}};
    localparam logic [MP_W-1:0]  HALF  = MP_W'(64'd1 << 29);

    localparam logic [3:0] G_X    = 4'd0;
    localparam logic [3:0] G_X2   = 4'd1;
    localparam logic [3:0] G_MUL  = 4'd2;
    localparam logic [3:0] G_RCP  = 4'd3;
    localparam logic [3:0] G_COR  = 4'd4;
    localparam logic [3:0] G_ACC  = 4'd5;
    localparam logic [3:0] G_MAG  = 4'd6;
    localparam logic [3:0] G_WR   = 4'd7;
    localparam logic [3:0] G_DONE = 4'd8;

    logic [3:0]        r_state, n_state;
    logic [IDX_W-1:0]  r_idx;
    logic [31:0]       r_ph_q;
    logic [IDX_W-1:0]  r_ph_r;
    logic              r_done;
    logic              r_neg;
    logic [30:0]       r_x;
    logic [31:0]       r_x2;
    logic [30:0]       r_term;
    logic signed [33:0] r_sum;
    logic [2:0]        r_k;
    logic [31:0]       r_n;
    logic [61:0]       r_qm;
    logic [29:0]       r_q0;
    logic [31:0]       r_qd;
    logic [MP_W-1:0]   r_mp;

    logic [30:0]       w_r;
    logic [61:0]       w_xp;
    logic [61:0]       w_x2p;
    logic [62:0]       w_np;
    logic [61:0]       w_qm;
    logic [38:0]       w_qd;
    logic [31:0]       w_rem;
    logic [29:0]       w_q;
    logic [8:0]        w_div;
    logic [30:0]       w_sat;
    logic [MP_W-1:0]   w_mr;
    logic [AMP_W-1:0]  w_mag;
    logic [IDX_W:0]    w_rsum;
    logic              w_carry;
    logic              w_last;

    // fold the phase into the first quadrant
    assign w_r   = r_ph_q[30] ? (Q30_ONE - {1'b0, r_ph_q[29:0]}) : {1'b0, r_ph_q[29:0]};
    assign w_xp  = 62'(w_r) * 62'(Q30_HALF_PI);
    assign w_x2p = 62'(r_x) * 62'(r_x);
    assign w_np  = 63'(r_term) * 63'(r_x2);
    assign w_div = f_series_div(r_k);
    assign w_qm  = 62'(r_n) * 62'(f_series_rcp(r_k));
    assign w_qd  = 39'(r_qm[61:32]) * 39'(w_div);
    assign w_rem = r_n - r_qd;
    assign w_q   = (w_rem >= {23'd0, w_div}) ? (r_q0 + 30'd1) : r_q0;

    always_comb begin
        if (r_sum < 0) begin
            w_sat = '0;
        end else if (r_sum > 34'sd1073741824) begin
            w_sat = Q30_ONE;
        end else begin
            w_sat = r_sum[30:0];
        end
    end

    assign w_mr    = r_mp + HALF;
    assign w_mag   = w_mr[30 + AMP_W - 1:30];
    assign w_rsum  = {1'b0, r_ph_r} + {1'b0, INC_R};
    assign w_carry = (w_rsum >= LEN_C);
    assign w_last  = (r_idx == IDX_W'(TABLE_LEN - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            G_X:    n_state = G_X2;
            G_X2:   n_state = G_MUL;
            G_MUL:  n_state = G_RCP;
            G_RCP:  n_state = G_COR;
            G_COR:  n_state = G_ACC;
            G_ACC:  n_state = (r_k == 3'd7) ? G_MAG : G_MUL;
            G_MAG:  n_state = G_WR;
            G_WR:   n_state = w_last ? G_DONE : G_X;
            G_DONE: n_state = G_DONE;
            default: n_state = G_X;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= G_X;
            r_idx   <= '0;
            r_ph_q  <= '0;
            r_ph_r  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == G_WR) begin
                if (w_last) begin
                    r_done <= 1'b1;
                end else begin
                    r_idx  <= r_idx + IDX_W'(1);
                    r_ph_q <= r_ph_q + INC_Q + 32'(w_carry);
                    r_ph_r <= w_carry ? IDX_W'(w_rsum - LEN_C) : w_rsum[IDX_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            G_X: begin
                r_x   <= w_xp[60:30];
                r_neg <= r_ph_q[31];
            end
            G_X2: begin
                r_x2   <= w_x2p[61:30];
                r_term <= r_x;
                r_sum  <= $signed({3'b000, r_x});
                r_k    <= 3'd0;
            end
            G_MUL: r_n <= w_np[61:30];
            G_RCP: r_qm <= w_qm;
            G_COR: begin
                r_q0 <= r_qm[61:32];
                r_qd <= w_qd[31:0];
            end
            G_ACC: begin
                r_term <= {1'b0, w_q};
                // odd terms of the series subtract
                if (!r_k[0]) begin
                    r_sum <= r_sum - $signed({4'b0000, w_q});
                end else begin
                    r_sum <= r_sum + $signed({4'b0000, w_q});
                end
                r_k <= r_k + 3'd1;
            end
            G_MAG: r_mp <= MP_W'(w_sat) * MP_W'(AMP);
            default: ;
        endcase
    end

    always_comb begin
        if (r_neg) begin
            o_wr_data = SAMPLE_BITS'(-$signed({1'b0, w_mag}));
        end else begin
            o_wr_data = SAMPLE_BITS'({1'b0, w_mag});
        end
    end

    assign o_wr_en   = (r_state == G_WR);
    assign o_wr_addr = r_idx;
    assign o_done    = r_done;

endmodule

// ===== design/ksyn_ctrl.sv =====
`timescale 1ns / 1ps
// controller state machine: request acceptance, voice issue, result hand-off
module ksyn_ctrl #(
    parameter int NUM_VOICES = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fill_done,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    input  ksyn_pkg::t_dp_sts i_sts,
    output ksyn_pkg::t_dp_cmd o_cmd
);

    import ksyn_pkg::*;

    localparam logic [2:0] C_FILL  = 3'd0;
    localparam logic [2:0] C_IDLE  = 3'd1;
    localparam logic [2:0] C_ISSUE = 3'd2;
    localparam logic [2:0] C_DRAIN = 3'd3;
    localparam logic [2:0] C_OUT   = 3'd4;

    logic [2:0]         r_state, n_state;
    logic [VOICE_W-1:0] r_voice, n_voice;
    logic               r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_voice     = r_voice;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            C_FILL: begin
                if (i_fill_done) begin
                    n_state = C_IDLE;
                end
            end
            C_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    if (i_sts.emit) begin
                        n_state = C_ISSUE;
                        n_voice = '0;
                    end
                end
            end
            C_ISSUE: begin
                o_cmd.issue = 1'b1;
                o_cmd.voice = r_voice;
                if (r_voice == VOICE_W'(NUM_VOICES - 1)) begin
                    n_state = C_DRAIN;
                end else begin
                    n_voice = r_voice + VOICE_W'(1);
                end
            end
            C_DRAIN: begin
                if (!i_sts.busy) begin
                    n_state = C_OUT;
                end
            end
            C_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.load  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = C_IDLE;
                end
            end
            default: n_state = C_FILL;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= C_FILL;
            r_voice     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_voice     <= n_voice;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != C_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== design/ksyn_dp.sv =====
`timescale 1ns / 1ps
// datapath: key state, tick counter, voice index pipeline, mixer and output register
module ksyn_dp #(
    parameter int TABLE_LEN   = 48000,
    parameter int DECIMATE    = 10,
    parameter int NUM_VOICES  = 8,
    parameter int MAX_VOLUME  = 10,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ksyn_pkg::t_dp_cmd                   i_cmd,
    output ksyn_pkg::t_dp_sts                   o_sts,
    input  logic                                i_scan_valid,
    input  logic [7:0]                          i_scan_byte,
    input  logic                                i_cfg_we,
    input  logic [ksyn_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ksyn_pkg::STEP_W-1:0]         i_cfg_data,
    output logic [$clog2(TABLE_LEN)-1:0]        o_rd_addr,
    input  logic [SAMPLE_BITS-1:0]              i_rd_data,
    output logic signed [ksyn_pkg::OUT_W-1:0]   o_sample_value,
    output logic [ksyn_pkg::KEY_W-1:0]          o_keys_held,
    output logic [ksyn_pkg::VOL_W-1:0]          o_volume_level
);

    import ksyn_pkg::*;

    localparam int IDX_W   = $clog2(TABLE_LEN);
    localparam int DEC_W   = $clog2(DECIMATE + 1);
    localparam int RECIP_W = 32 - IDX_W;
    localparam int QM_W    = PROD_W + RECIP_W;
    localparam int QL_W    = RECIP_W + TICK_W;
    localparam int ACC_W   = SAMPLE_BITS + VOICE_W;
    localparam int SCL_W   = ACC_W + VOL_W + 1;
    localparam logic [RECIP_W-1:0] MOD_RECIP = RECIP_W'((64'd1 << 31) / TABLE_LEN);
    localparam logic [IDX_W:0]     LEN_C     = (IDX_W + 1)'(TABLE_LEN);

    logic [STEP_W-1:0]   r_step [NUM_CFG];
    logic [KEY_W-1:0]    r_keys, n_keys;
    logic                r_armed, n_armed;
    logic [VOL_W-1:0]    r_vol, n_vol;
    logic [TICK_W-1:0]   r_tick;
    logic [DEC_W-1:0]    r_dec;
    logic [TICK_W-1:0]   r_item_tick;

    logic                r_v1, r_v2, r_v3, r_v4;
    logic                r_u1, r_u2, r_u3, r_u4;
    logic [PROD_W-1:0]   r_prod1, r_prod2, r_prod3;
    logic [QM_W-1:0]     r_qm2;
    logic [PROD_W-1:0]   r_ql3;
    logic signed [ACC_W-1:0] r_acc;

    logic signed [OUT_W-1:0] r_sample;
    logic [KEY_W-1:0]    r_keys_out;
    logic [VOL_W-1:0]    r_vol_out;

    logic                w_note_hit;
    logic [VOICE_W-1:0]  w_note;
    logic [QL_W-1:0]     w_ql;
    logic [PROD_W-1:0]   w_diff;
    logic [IDX_W:0]      w_d;
    logic [IDX_W:0]      w_dsub;
    logic signed [SCL_W-1:0] w_scaled;

    // scan byte decode
    always_comb begin
        n_keys     = r_keys;
        n_armed    = r_armed;
        n_vol      = r_vol;
        w_note_hit = 1'b0;
        w_note     = '0;
        for (int i = 0; i < NUM_VOICES; i++) begin
            if (i_scan_byte == NOTE_CODES[i]) begin
                w_note_hit = 1'b1;
                w_note     = VOICE_W'(i);
            end
        end
        if (i_scan_valid) begin
            if (w_note_hit) begin
                if (r_armed) begin
                    n_keys[w_note] = 1'b0;
                    n_armed        = 1'b0;
                end else begin
                    n_keys[w_note] = 1'b1;
                end
            end else if (i_scan_byte == VOL_UP_CODE) begin
                if (r_armed) begin
                    if (r_vol < VOL_W'(MAX_VOLUME)) begin
                        n_vol = r_vol + VOL_W'(1);
                    end
                    n_armed = 1'b0;
                end
            end else if (i_scan_byte == VOL_DOWN_CODE) begin
                if (r_armed) begin
                    if (r_vol > VOL_W'(1)) begin
                        n_vol = r_vol - VOL_W'(1);
                    end
                    n_armed = 1'b0;
                end
            end else if (i_scan_byte == BREAK_CODE) begin
                n_armed = 1'b1;
            end else begin
                n_armed = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CFG; i++) begin
                r_step[i] <= STEP_RESET[i];
            end
            r_keys  <= '0;
            r_armed <= 1'b0;
            r_vol   <= VOL_W'(1);
            r_tick  <= '0;
            r_dec   <= '0;
        end else begin
            for (int i = 0; i < NUM_CFG; i++) begin
                if (i_cfg_we && (i_cfg_index == CFG_IDX_W'(i))) begin
                    r_step[i] <= i_cfg_data;
                end
            end
            if (i_cmd.take) begin
                r_keys  <= n_keys;
                r_armed <= n_armed;
                r_vol   <= n_vol;
                if (r_tick == TICK_W'(TABLE_LEN)) begin
                    r_tick <= '0;
                    r_dec  <= '0;
                end else begin
                    r_tick <= r_tick + TICK_W'(1);
                    r_dec  <= (r_dec == DEC_W'(DECIMATE - 1)) ? '0 : (r_dec + DEC_W'(1));
                end
            end
        end
    end

    // index pipeline: step * tick, then mod table length by reciprocal
    assign w_ql   = QL_W'(r_qm2[QM_W-1:31]) * QL_W'(TABLE_LEN);
    assign w_diff = r_prod3 - r_ql3;
    assign w_d    = w_diff[IDX_W:0];
    assign w_dsub = w_d - LEN_C;
    assign o_rd_addr = (w_d >= LEN_C) ? w_dsub[IDX_W-1:0] : w_d[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_item_tick <= r_tick;
        end
        r_prod1 <= PROD_W'(r_step[i_cmd.voice]) * PROD_W'(r_item_tick);
        r_u1    <= r_keys[i_cmd.voice];
        r_qm2   <= QM_W'(r_prod1) * QM_W'(MOD_RECIP);
        r_prod2 <= r_prod1;
        r_u2    <= r_u1;
        r_ql3   <= w_ql[PROD_W-1:0];
        r_prod3 <= r_prod2;
        r_u3    <= r_u2;
        r_u4    <= r_u3;
        if (i_cmd.take) begin
            r_acc <= '0;
        end else if (r_v4 && r_u4) begin
            r_acc <= r_acc + $signed({{VOICE_W{i_rd_data[SAMPLE_BITS-1]}}, i_rd_data});
        end
    end

    // volume scaling into the output register
    assign w_scaled = r_acc * $signed({1'b0, r_vol});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sample   <= OUT_W'(w_scaled);
            r_keys_out <= r_keys;
            r_vol_out  <= r_vol;
        end
    end

    assign o_sts.emit = (r_dec == '0);
    assign o_sts.busy = r_v1 | r_v2 | r_v3 | r_v4;

    assign o_sample_value = r_sample;
    assign o_keys_held    = r_keys_out;
    assign o_volume_level = r_vol_out;

endmodule

// ===== design/keyboard_polyphonic_sine_synth.sv =====
`timescale 1ns / 1ps
// top level of the polyphonic keyboard sine synthesizer
//
// One request is one audio sample tick, optionally carrying a PS/2 set 2 scan
// byte. Scan bytes press and release up to eight note keys (break prefix F0
// then the key code releases), and released plus/minus keys step the volume
// between 1 and MAX_VOLUME. Each tick where the tick counter is a multiple of
// DECIMATE produces one result: the sum of the sine table entries at
// (note step * tick) mod TABLE_LEN over all pressed voices, times the volume,
// together with the key mask and volume. The tick counter runs 0..TABLE_LEN
// inclusive and wraps. After reset the block computes the one-period sine
// table into its wave ram, during which no request is accepted; note step
// registers may be written at any time while the block is idle. A tick with
// no result does not hold off the next request. A tick with a result holds
// off further requests while the voices read the single wave ram read port
// one after another through an index and read pipeline (step product,
// reciprocal product, quotient product, ram read), and while the output
// register still holds an untaken result. The result sits in an output
// register, so it may wait while the next request is already being taken.
module keyboard_polyphonic_sine_synth #(
    parameter int TABLE_LEN   = 48000,
    parameter int DECIMATE    = 10,
    parameter int NUM_VOICES  = 8,
    parameter int MAX_VOLUME  = 10,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // tick request channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_scan_valid,
    input  logic [7:0]                        i_scan_byte,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [ksyn_pkg::OUT_W-1:0] o_sample_value,
    output logic [ksyn_pkg::KEY_W-1:0]        o_keys_held,
    output logic [ksyn_pkg::VOL_W-1:0]        o_volume_level,
    // note step register writes
    input  logic                              i_cfg_we,
    input  logic [ksyn_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ksyn_pkg::STEP_W-1:0]       i_cfg_data
);

    import ksyn_pkg::*;

    localparam int IDX_W = $clog2(TABLE_LEN);

    t_dp_cmd                w_cmd;
    t_dp_sts                w_sts;
    logic                   w_fill_done;
    logic                   w_wr_en;
    logic [IDX_W-1:0]       w_wr_addr;
    logic [SAMPLE_BITS-1:0] w_wr_data;
    logic [IDX_W-1:0]       w_rd_addr;
    logic [SAMPLE_BITS-1:0] w_rd_data;

    // builds the sine period once after reset
    ksyn_sine_gen #(
        .TABLE_LEN   (TABLE_LEN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_sine_gen (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .o_wr_en   (w_wr_en),
        .o_wr_addr (w_wr_addr),
        .o_wr_data (w_wr_data),
        .o_done    (w_fill_done)
    );

    // wave table: written by the generator, read by the voice pipeline
    ksyn_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (TABLE_LEN)
    ) u_wave_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // sequences take, voice issue, drain and output load
    ksyn_ctrl #(
        .NUM_VOICES (NUM_VOICES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fill_done (w_fill_done),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // key state, tick count, index math, mixing and output register
    ksyn_dp #(
        .TABLE_LEN   (TABLE_LEN),
        .DECIMATE    (DECIMATE),
        .NUM_VOICES  (NUM_VOICES),
        .MAX_VOLUME  (MAX_VOLUME),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_scan_valid   (i_scan_valid),
        .i_scan_byte    (i_scan_byte),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_rd_addr      (w_rd_addr),
        .i_rd_data      (w_rd_data),
        .o_sample_value (o_sample_value),
        .o_keys_held    (o_keys_held),
        .o_volume_level (o_volume_level)
    );

    // no request may enter before the wave table is complete
    a_no_accept_during_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_fill_done |-> o_in_stall)
        else $error("request accepted while the wave table is being filled");

    // voice issue only happens while requests are held off
    a_issue_while_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.issue |-> o_in_stall)
        else $error("voice issued while the request channel is open");

    // only implemented voices can be held
    a_keys_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_keys_held >> NUM_VOICES) == '0))
        else $error("key held beyond the number of voices");

    // volume stays saturated within its range
    a_volume_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_volume_level != '0) && (o_volume_level <= VOL_W'(MAX_VOLUME)))
        else $error("volume level out of range");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the polyphonic keyboard sine synth
module tb_top;
    import ksyn_pkg::*;

    // block configuration, kept in step with the instance below
    localparam int TABLE_LEN   = 48000;
    localparam int DECIMATE    = 10;
    localparam int NUM_VOICES  = 8;
    localparam int MAX_VOLUME  = 10;
    localparam int SAMPLE_BITS = 24;

    // margin that covers a result tick plus the wait for the output register
    localparam int DRAIN_CYCLES = 40;
    // the limit covers the wave ram build after reset, during which no request is taken
    localparam int STUCK_LIMIT  = 7_000_000;
    // receiver hold-off long enough to back the block up into its request side
    localparam int LONG_HOLD    = 400;
    localparam int LAST_CFG_IDX = (1 << CFG_IDX_W) - 1;
    localparam int MAX_STEP     = (1 << STEP_W) - 1;
    localparam int TOP_STEP     = 24000;

    typedef longint unsigned t_u64;

    localparam t_u64 Q30_UNIT   = t_u64'(Q30_ONE);
    localparam t_u64 Q30_HPI    = t_u64'(Q30_HALF_PI);
    localparam t_u64 WAVE_AMP   = (t_u64'(1) << (SAMPLE_BITS - 1)) - 1;

    typedef struct packed {
        logic       scan_valid;
        logic [7:0] scan_byte;
    } t_tick_req;

    typedef struct packed {
        logic signed [OUT_W-1:0] value;
        logic [KEY_W-1:0]        keys;
        logic [VOL_W-1:0]        volume;
    } t_sample;

    // keyboard activity that one random draw turns into one or more ticks
    typedef enum {
        KEY_PRESS,
        KEY_RELEASE,
        VOLUME_UP,
        VOLUME_DOWN,
        QUIET_TICK,
        STRAY_BYTE,
        BROKEN_BREAK
    } t_kbd_event;

    // how the note steps are chosen for a phase
    typedef enum {
        STEPS_RANDOM,
        STEPS_ZERO,
        STEPS_TOP,
        STEPS_MAX,
        STEPS_WILD
    } t_steps_mode;

    // dut pins, inputs all known from time zero
    logic                    i_clk        = 1'b0;
    logic                    i_rst_n      = 1'b0;
    logic                    i_in_valid   = 1'b0;
    logic                    o_in_stall;
    logic                    i_scan_valid = 1'b0;
    logic [7:0]              i_scan_byte  = 8'h00;
    logic                    o_out_valid;
    logic                    i_out_stall  = 1'b0;
    logic signed [OUT_W-1:0] o_sample_value;
    logic [KEY_W-1:0]        o_keys_held;
    logic [VOL_W-1:0]        o_volume_level;
    logic                    i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index  = '0;
    logic [STEP_W-1:0]       i_cfg_data   = '0;

    // shadow of the synth: sine table, note steps and keyboard state
    int                      sine_table [TABLE_LEN];
    logic [STEP_W-1:0]       step_regs [NUM_CFG];
    logic [KEY_W-1:0]        key_down;
    logic                    break_pending;
    logic [VOL_W-1:0]        volume;
    int                      tick_index;

    t_tick_req               tick_queue [$];
    t_sample                 pending_samples [$];
    int                      ticks_queued  = 0;
    int                      ticks_taken   = 0;
    int                      results_seen  = 0;
    int                      error_count   = 0;
    int                      stuck_cycles  = 0;

    // idling control, set per phase by the stimulus process
    bit                      sender_calm   = 1'b0;
    bit                      recv_calm     = 1'b0;
    int                      holds_ordered = 0;
    int                      holds_served  = 0;
    int                      tx_wait       = 0;
    int                      rx_wait       = 0;
    int                      hold_left     = 0;

    keyboard_polyphonic_sine_synth #(
        .TABLE_LEN  (TABLE_LEN),
        .DECIMATE   (DECIMATE),
        .NUM_VOICES (NUM_VOICES),
        .MAX_VOLUME (MAX_VOLUME),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_scan_valid  (i_scan_valid),
        .i_scan_byte   (i_scan_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_sample_value(o_sample_value),
        .o_keys_held   (o_keys_held),
        .o_volume_level(o_volume_level),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // sine table: 32-bit phase, quadrant fold, q30 taylor series,
    // magnitude rounded half up, then the quadrant sign
    // ------------------------------------------------------------------

    function automatic t_u64 quarter_wave(input t_u64 r);
        t_u64   x;
        t_u64   x2;
        t_u64   term;
        t_u64   k;
        longint acc;
        x    = (r * Q30_HPI) >> 30;
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (k = 1; k <= 8; k++) begin
            term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
            // odd terms subtract, even terms add
            if (k[0]) acc -= longint'(term);
            else acc += longint'(term);
        end
        if (acc < 0) acc = 0;
        if (acc > longint'(Q30_UNIT)) acc = longint'(Q30_UNIT);
        return t_u64'(acc);
    endfunction

    task automatic build_sine_table();
        t_u64 phase;
        t_u64 quad;
        t_u64 r;
        t_u64 mag;
        int   i;
        for (i = 0; i < TABLE_LEN; i++) begin
            phase = (t_u64'(i) << 32) / TABLE_LEN;
            quad  = (phase >> 30) & 3;
            r     = phase & (Q30_UNIT - 1);
            if (quad[0]) r = Q30_UNIT - r;
            mag = (quarter_wave(r) * WAVE_AMP + (Q30_UNIT >> 1)) >> 30;
            sine_table[i] = quad[1] ? -int'(mag) : int'(mag);
        end
    endtask

    // ------------------------------------------------------------------
    // one accepted tick: keyboard decode, then the sample on decimated ticks
    // ------------------------------------------------------------------

    task automatic advance_synth(input t_tick_req req);
        int      note;
        int      i;
        int      idx;
        longint  acc;
        t_sample want;
        note = -1;
        if (req.scan_valid) begin
            for (i = 0; i < NUM_VOICES; i++)
                if (NOTE_CODES[i] == req.scan_byte) note = i;
            if (note >= 0) begin
                // break prefix pending means this is the key coming up
                if (break_pending) begin
                    key_down[note] = 1'b0;
                    break_pending  = 1'b0;
                end else begin
                    key_down[note] = 1'b1;
                end
            end else if (req.scan_byte == VOL_UP_CODE) begin
                // volume keys act on release only
                if (break_pending) begin
                    if (volume < MAX_VOLUME) volume++;
                    break_pending = 1'b0;
                end
            end else if (req.scan_byte == VOL_DOWN_CODE) begin
                if (break_pending) begin
                    if (volume > 1) volume--;
                    break_pending = 1'b0;
                end
            end else if (req.scan_byte == BREAK_CODE) begin
                break_pending = 1'b1;
            end else begin
                break_pending = 1'b0;
            end
        end

        if (tick_index % DECIMATE == 0) begin
            acc = 0;
            for (i = 0; i < NUM_VOICES; i++) begin
                if (key_down[i]) begin
                    idx = (int'(step_regs[i]) * tick_index) % TABLE_LEN;
                    acc += sine_table[idx];
                end
            end
            acc         = acc * longint'(volume);
            want.value  = acc[OUT_W-1:0];
            want.keys   = key_down;
            want.volume = volume;
            pending_samples.push_back(want);
        end

        // counter runs 0..TABLE_LEN inclusive
        if (tick_index >= TABLE_LEN) tick_index = 0;
        else tick_index++;
    endtask

    // ------------------------------------------------------------------
    // request driver: pops queued ticks, a random gap (none while the sender is calm) after each acceptance
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin : tick_driver
        t_tick_req next_req;
        logic      offer;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            tx_wait = 0;
        end else begin
            offer = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                advance_synth({i_scan_valid, i_scan_byte});
                ticks_taken++;
                offer   = 1'b0;
                tx_wait = sender_calm ? 0 : $urandom_range(0, 9);
            end
            // payload only moves while nothing is offered
            if (!offer) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                end else if (tick_queue.size() != 0) begin
                    next_req = tick_queue.pop_front();
                    i_scan_valid <= next_req.scan_valid;
                    i_scan_byte  <= next_req.scan_byte;
                    offer = 1'b1;
                end
            end
            i_in_valid <= offer;
        end
    end

    // ------------------------------------------------------------------
    // result monitor: checks each sample and drives the receiver stall
    // ------------------------------------------------------------------

    function automatic void flag_mismatch(input string msg);
        if (error_count < 10) $display("mismatch: %s", msg);
        error_count++;
    endfunction

    always @(posedge i_clk) begin : result_monitor
        t_sample want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            rx_wait = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_samples.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result %0d: sample %0d keys %02h volume %0d",
                        results_seen, o_sample_value, o_keys_held, o_volume_level));
                end else begin
                    want = pending_samples.pop_front();
                    if (o_sample_value !== want.value || o_keys_held !== want.keys ||
                        o_volume_level !== want.volume)
                        flag_mismatch($sformatf(
                            "result %0d: expected %0d/%02h/%0d, got %0d/%02h/%0d",
                            results_seen, want.value, want.keys, want.volume,
                            o_sample_value, o_keys_held, o_volume_level));
                end
                results_seen++;
                rx_wait = recv_calm ? 0 : $urandom_range(0, 9);
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            // long hold-off ordered by the stimulus, counted here
            if (hold_left > 0) begin
                hold_left--;
            end else if (holds_served != holds_ordered) begin
                hold_left = LONG_HOLD;
                holds_served++;
            end
            i_out_stall <= (rx_wait > 0) || (hold_left > 0);
        end
    end

    // watchdog: any acceptance on either channel counts as progress
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) stuck_cycles = 0;
        else stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", STUCK_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    task automatic queue_tick(input logic scan_valid, input logic [7:0] scan_byte);
        tick_queue.push_back({scan_valid, scan_byte});
        ticks_queued++;
    endtask

    task automatic queue_event(input t_kbd_event ev);
        logic [7:0] code;
        code = NOTE_CODES[$urandom_range(0, NUM_VOICES - 1)];
        case (ev)
            KEY_PRESS: queue_tick(1'b1, code);
            KEY_RELEASE: begin
                queue_tick(1'b1, BREAK_CODE);
                queue_tick(1'b1, code);
            end
            VOLUME_UP: begin
                queue_tick(1'b1, BREAK_CODE);
                queue_tick(1'b1, VOL_UP_CODE);
            end
            VOLUME_DOWN: begin
                queue_tick(1'b1, BREAK_CODE);
                queue_tick(1'b1, VOL_DOWN_CODE);
            end
            QUIET_TICK: queue_tick(1'b0, 8'($urandom_range(0, 255)));
            STRAY_BYTE: queue_tick(1'b1, 8'($urandom_range(0, 255)));
            default: begin
                // break prefix, maybe a tick with no byte, then anything at all
                queue_tick(1'b1, BREAK_CODE);
                if ($urandom_range(0, 1)) queue_tick(1'b0, 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 1)) queue_tick(1'b1, 8'($urandom_range(0, 255)));
                else queue_tick(1'b1, code);
            end
        endcase
    endtask

    // mostly well-formed key traffic, some noise and broken break sequences
    task automatic queue_random(input int count);
        int stop_at;
        int pick;
        int n;
        stop_at = ticks_queued + count;
        while (ticks_queued < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                queue_event(KEY_PRESS);
            end else if (pick < 58) begin
                queue_event(KEY_RELEASE);
            end else if (pick < 70) begin
                // runs of volume steps reach both ends of the range
                for (n = $urandom_range(1, 10); n > 0; n--) queue_event(VOLUME_UP);
            end else if (pick < 80) begin
                for (n = $urandom_range(1, 10); n > 0; n--) queue_event(VOLUME_DOWN);
            end else if (pick < 88) begin
                queue_event(QUIET_TICK);
            end else if (pick < 94) begin
                queue_event(STRAY_BYTE);
            end else begin
                queue_event(BROKEN_BREAK);
            end
        end
    endtask

    // stretch of mostly empty ticks with an occasional key event
    task automatic queue_long_run(input int count);
        int stop_at;
        stop_at = ticks_queued + count;
        while (ticks_queued < stop_at) begin
            if ($urandom_range(0, 59) == 0)
                queue_event(t_kbd_event'($urandom_range(KEY_PRESS, VOLUME_DOWN)));
            else
                queue_event(QUIET_TICK);
        end
    endtask

    function automatic logic [STEP_W-1:0] pick_step(input t_steps_mode mode);
        logic [STEP_W-1:0] val;
        case (mode)
            STEPS_ZERO: val = '0;
            STEPS_TOP:  val = STEP_W'(TOP_STEP);
            STEPS_MAX:  val = STEP_W'(MAX_STEP);
            STEPS_WILD: begin
                case ($urandom_range(0, 3))
                    0: val = '0;
                    1: val = STEP_W'(TOP_STEP);
                    2: val = STEP_W'(MAX_STEP);
                    default: val = STEP_W'($urandom_range(0, MAX_STEP));
                endcase
            end
            default: val = STEP_W'($urandom_range(0, TOP_STEP));
        endcase
        return val;
    endfunction

    task automatic write_step(input logic [CFG_IDX_W-1:0] idx, input logic [STEP_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        // indexes past the note step list are dropped by the block
        if (idx < NUM_CFG) step_regs[idx] = val;
    endtask

    // all eight note steps plus one write to an unused index
    task automatic load_steps(input t_steps_mode mode);
        int i;
        write_step(CFG_IDX_W'($urandom_range(NUM_CFG, LAST_CFG_IDX)),
                   STEP_W'($urandom_range(0, MAX_STEP)));
        for (i = 0; i < NUM_CFG; i++) write_step(CFG_IDX_W'(i), pick_step(mode));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // wait until every queued tick is taken and every sample checked,
    // then let the block finish any tick that makes no sample
    task automatic drain();
        while (ticks_taken != ticks_queued || pending_samples.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic shuffle_idling();
        sender_calm = ($urandom_range(0, 2) == 0);
        recv_calm   = ($urandom_range(0, 2) == 0);
    endtask

    // ------------------------------------------------------------------
    // run: directed ticks, then phases at several note step settings
    // ------------------------------------------------------------------

    initial begin
        int i;
        build_sine_table();
        for (i = 0; i < NUM_CFG; i++) step_regs[i] = STEP_RESET[i];
        key_down      = '0;
        break_pending = 1'b0;
        volume        = 1;
        tick_index    = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // phase at reset steps; the block builds its wave ram first
        shuffle_idling();
        // byte with no scan flag is ignored, break prefix too
        queue_tick(1'b0, 8'hFF);
        queue_tick(1'b0, BREAK_CODE);
        // every note key down
        for (i = 0; i < NUM_VOICES; i++) queue_tick(1'b1, NOTE_CODES[i]);
        // volume keys without break prefix do nothing
        queue_tick(1'b1, VOL_UP_CODE);
        queue_tick(1'b1, VOL_DOWN_CODE);
        queue_event(VOLUME_UP);
        queue_event(VOLUME_DOWN);
        // volume already at the bottom
        queue_event(VOLUME_DOWN);
        // other byte cancels a pending break, so the key stays down
        queue_tick(1'b1, BREAK_CODE);
        queue_tick(1'b1, 8'h00);
        queue_tick(1'b1, NOTE_CODES[1]);
        // double break prefix still releases
        queue_tick(1'b1, BREAK_CODE);
        queue_tick(1'b1, BREAK_CODE);
        queue_tick(1'b1, NOTE_CODES[0]);
        queue_tick(1'b1, 8'hFF);
        queue_random(150);
        drain();

        shuffle_idling();
        load_steps(STEPS_RANDOM);
        queue_random(250);
        drain();

        shuffle_idling();
        load_steps(STEPS_ZERO);
        queue_random(150);
        drain();

        shuffle_idling();
        load_steps(STEPS_MAX);
        queue_random(150);
        drain();

        shuffle_idling();
        load_steps(STEPS_TOP);
        queue_random(150);
        drain();

        // sparse key traffic, sender never idles
        sender_calm = 1'b1;
        recv_calm   = ($urandom_range(0, 1) == 0);
        load_steps(STEPS_RANDOM);
        queue_long_run(100);
        drain();

        // receiver holds off while the sender keeps offering
        sender_calm = 1'b1;
        recv_calm   = 1'b0;
        load_steps(STEPS_WILD);
        holds_ordered++;
        queue_random(400);
        drain();

        shuffle_idling();
        load_steps(STEPS_WILD);
        queue_random(300);
        drain();

        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== keyboard_polyphonic_sine_synth.f =====
design/ksyn_pkg.sv
design/ksyn_ram.sv
design/ksyn_sine_gen.sv
design/ksyn_ctrl.sv
design/ksyn_dp.sv
design/keyboard_polyphonic_sine_synth.sv
tb/sv/tb_top.sv
